### rtl/core/rau_pkg.sv
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int RES_WIDTH     = 33;
    // Working width of cross products and of the GCD datapath.
    localparam int WORK_WIDTH    = 2 * OPERAND_WIDTH + 1;
    localparam int CNT_WIDTH     = $clog2(WORK_WIDTH + 1);
    localparam int QUEUE_DEPTH   = 2;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_ADD = 2'd0;
    localparam kind_t KIND_SUB = 2'd1;
    localparam kind_t KIND_MUL = 2'd2;
    localparam kind_t KIND_DIV = 2'd3;

    typedef logic signed [WORK_WIDTH-1:0] work_t;

    // Classified item handed from the front to the back.
    typedef struct packed {
        work_t num;
        work_t den;
        logic  div_zero;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_DONE
    } back_state_t;

endpackage

### rtl/core/rational_arithmetic_unit.sv
// Rational arithmetic unit: adds, subtracts, multiplies or divides two signed
// 16-bit fractions and returns the result reduced by its GCD (truncating
// remainder, so signs follow the dividend), in 33-bit fields. A two-stage front
// forms the cross products and feeds a two-entry queue; the back runs Euclid's
// loop and the two final divisions on one bit-serial divider. Division by a
// zero fraction returns the first fraction, unreduced, with div_zero set.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  kind_t                           s_kind,
    input  logic signed [OPERAND_WIDTH-1:0] s_a_num,
    input  logic signed [OPERAND_WIDTH-1:0] s_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] s_b_num,
    input  logic signed [OPERAND_WIDTH-1:0] s_b_den,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [RES_WIDTH-1:0]     m_res_num,
    output logic signed [RES_WIDTH-1:0]     m_res_den,
    output logic                            m_div_zero
);

    logic f_valid, f_ready, b_valid, b_ready;
    job_t f_job, b_job;

    rau_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_kind    (s_kind),
        .s_a_num   (s_a_num),
        .s_a_den   (s_a_den),
        .s_b_num   (s_b_num),
        .s_b_den   (s_b_den),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    rau_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_job    (f_job),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_job   (b_job)
    );

    rau_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (b_valid),
        .job_ready  (b_ready),
        .job        (b_job),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res_num  (m_res_num),
        .m_res_den  (m_res_den),
        .m_div_zero (m_div_zero)
    );

endmodule

### rtl/core/rau_divider.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module rau_divider
    import rau_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  work_t dividend,
    input  work_t divisor,
    output logic  done,
    output work_t quotient,
    output work_t remainder
);

    typedef logic [WORK_WIDTH-1:0] mag_t;

    mag_t                 rem_reg, rem_next;
    mag_t                 quo_reg, quo_next;
    mag_t                 dsr_reg, dsr_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 qneg_reg, qneg_next;
    logic                 rneg_reg, rneg_next;
    logic [WORK_WIDTH:0]  trial;
    mag_t                 shifted;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[WORK_WIDTH-2:0], quo_reg[WORK_WIDTH-1]};
        trial     = {rem_reg, quo_reg[WORK_WIDTH-1]} - {1'b0, dsr_reg};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend[WORK_WIDTH-1] ? mag_t'(-dividend) : mag_t'(dividend);
            dsr_next  = divisor[WORK_WIDTH-1] ? mag_t'(-divisor) : mag_t'(divisor);
            qneg_next = dividend[WORK_WIDTH-1] ^ divisor[WORK_WIDTH-1];
            rneg_next = dividend[WORK_WIDTH-1];
            cnt_next  = CNT_WIDTH'(WORK_WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[WORK_WIDTH]) begin
                rem_next = trial[WORK_WIDTH-1:0];
                quo_next = {quo_reg[WORK_WIDTH-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[WORK_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_WIDTH'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dsr_reg  <= dsr_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign done      = done_reg;
    assign quotient  = qneg_reg ? -work_t'(quo_reg) : work_t'(quo_reg);
    assign remainder = rneg_reg ? -work_t'(rem_reg) : work_t'(rem_reg);

endmodule

### rtl/core/rau_front.sv
// Accepts items, applies the zero-denominator rule and forms the cross products.
module rau_front
    import rau_pkg::*;
(
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  kind_t                           s_kind,
    input  logic signed [OPERAND_WIDTH-1:0] s_a_num,
    input  logic signed [OPERAND_WIDTH-1:0] s_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] s_b_num,
    input  logic signed [OPERAND_WIDTH-1:0] s_b_den,
    output logic                            job_valid,
    input  logic                            job_ready,
    output job_t                            job
);

    localparam int PW = 2 * OPERAND_WIDTH;

    typedef logic signed [OPERAND_WIDTH-1:0] op_t;
    typedef logic signed [PW-1:0]            prod_t;

    logic  st1_valid_reg;
    kind_t kind_reg;
    op_t   an_reg, ad_reg, bn_reg, bd_reg;
    logic  st2_valid_reg;
    kind_t kind2_reg;
    logic  dz_reg;
    op_t   an2_reg, ad2_reg;
    prod_t p0_reg, p1_reg, p2_reg;
    op_t   ad_fix, bd_fix;
    prod_t m0, m1, m2;
    logic  adv1, adv2;
    work_t num_sel, den_sel;

    assign ad_fix = (s_a_den == '0) ? op_t'(1) : s_a_den;
    assign bd_fix = (s_b_den == '0) ? op_t'(1) : s_b_den;

    assign adv2    = !st2_valid_reg || job_ready;
    assign adv1    = !st1_valid_reg || adv2;
    assign s_ready = adv1;

    // The first stage forms all three products; an*bd and ad*bd are shared by the kinds.
    always_comb begin
        m0 = prod_t'(an_reg) * prod_t'(bd_reg);
        m2 = prod_t'(ad_reg) * prod_t'(bd_reg);
        case (kind_reg)
            KIND_MUL: m1 = prod_t'(an_reg) * prod_t'(bn_reg);
            KIND_DIV: m1 = prod_t'(ad_reg) * prod_t'(bn_reg);
            default:  m1 = prod_t'(bn_reg) * prod_t'(ad_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end else begin
            if (adv1) begin
                st1_valid_reg <= s_valid;
            end
            if (adv2) begin
                st2_valid_reg <= st1_valid_reg;
            end
        end
        if (adv1 && s_valid) begin
            kind_reg <= s_kind;
            an_reg   <= s_a_num;
            ad_reg   <= ad_fix;
            bn_reg   <= s_b_num;
            bd_reg   <= bd_fix;
        end
        if (adv2 && st1_valid_reg) begin
            kind2_reg <= kind_reg;
            dz_reg    <= (kind_reg == KIND_DIV) && (bn_reg == '0);
            an2_reg   <= an_reg;
            ad2_reg   <= ad_reg;
            p0_reg    <= m0;
            p1_reg    <= m1;
            p2_reg    <= m2;
        end
    end

    always_comb begin
        case (kind2_reg)
            KIND_ADD: begin
                num_sel = work_t'(p0_reg) + work_t'(p1_reg);
                den_sel = work_t'(p2_reg);
            end
            KIND_SUB: begin
                num_sel = work_t'(p0_reg) - work_t'(p1_reg);
                den_sel = work_t'(p2_reg);
            end
            KIND_MUL: begin
                num_sel = work_t'(p1_reg);
                den_sel = work_t'(p2_reg);
            end
            default: begin
                num_sel = work_t'(p0_reg);
                den_sel = work_t'(p1_reg);
            end
        endcase
        if (dz_reg) begin
            num_sel = work_t'(an2_reg);
            den_sel = work_t'(ad2_reg);
        end
    end

    assign job_valid    = st2_valid_reg;
    assign job.num      = num_sel;
    assign job.den      = den_sel;
    assign job.div_zero = dz_reg;

endmodule

### rtl/core/rau_queue.sv
// Small FIFO between the front and the back.
module rau_queue
    import rau_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    job_t          mem_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign in_ready  = cnt_reg != (AW+1)'(QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_job   = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
        if (push) begin
            mem_reg[wr_reg] <= in_job;
        end
    end

endmodule

### rtl/core/rau_back.sv
// Euclid reduction on one shared divider, then the two exact divisions.
module rau_back
    import rau_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        job_valid,
    output logic                        job_ready,
    input  job_t                        job,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [RES_WIDTH-1:0] m_res_num,
    output logic signed [RES_WIDTH-1:0] m_res_den,
    output logic                        m_div_zero
);

    back_state_t state_reg, state_next;
    work_t       n_reg, n_next;
    work_t       d_reg, d_next;
    work_t       x_reg, x_next;
    work_t       y_reg, y_next;
    logic        dz_reg, dz_next;
    logic        div_start;
    work_t       div_a, div_b;
    logic        div_done;
    work_t       div_q, div_r;

    rau_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        n_reg  <= n_next;
        d_reg  <= d_next;
        x_reg  <= x_next;
        y_reg  <= y_next;
        dz_reg <= dz_next;
    end

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        dz_next    = dz_reg;
        div_start  = 1'b0;
        div_a      = x_reg;
        div_b      = y_reg;
        job_ready  = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    n_next  = job.num;
                    d_next  = job.den;
                    x_next  = job.num;
                    y_next  = job.den;
                    dz_next = job.div_zero;
                    if (job.div_zero) begin
                        state_next = ST_DONE;
                    end else if (job.den == '0) begin
                        state_next = ST_GCD;
                    end else begin
                        div_start  = 1'b1;
                        div_a      = job.num;
                        div_b      = job.den;
                        state_next = ST_GCD;
                    end
                end
            end
            ST_GCD: begin
                // y is the divisor in flight; x holds the GCD once y reaches zero.
                if (y_reg == '0) begin
                    if (x_reg == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        div_start  = 1'b1;
                        div_a      = n_reg;
                        div_b      = x_reg;
                        state_next = ST_DIV_NUM;
                    end
                end else if (div_done) begin
                    x_next = y_reg;
                    y_next = div_r;
                    if (div_r != '0) begin
                        div_start = 1'b1;
                        div_a     = y_reg;
                        div_b     = div_r;
                    end
                end
            end
            ST_DIV_NUM: begin
                if (div_done) begin
                    n_next     = div_q;
                    div_start  = 1'b1;
                    div_a      = d_reg;
                    div_b      = x_reg;
                    state_next = ST_DIV_DEN;
                end
            end
            ST_DIV_DEN: begin
                if (div_done) begin
                    d_next     = div_q;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_res_num  = n_reg[RES_WIDTH-1:0];
    assign m_res_den  = d_reg[RES_WIDTH-1:0];
    assign m_div_zero = dz_reg;

endmodule
